// ===== hw/rtl/bdd_pkg.sv =====
package bdd_pkg;

    localparam int ENERGY_W   = 18;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [FRAC_W-1:0]   ONE_Q15    = 16'd32768;
    localparam logic [FRAC_W-1:0]   HALF_Q15   = 16'd16384;
    localparam logic [ENERGY_W-1:0] ONE_Q8     = 18'd256;
    localparam logic [ENERGY_W-1:0] PEAK_RESET = 18'd5120;
    localparam logic [16:0]         PEAK_DECAY = 17'd65470;

    localparam logic [ENERGY_W-1:0] W_BIN0 = 18'd384;
    localparam logic [ENERGY_W-1:0] W_BIN1 = 18'd179;
    localparam logic [ENERGY_W-1:0] W_BIN2 = 18'd77;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRONG_FRACTION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_FRACTION     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_RISE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUILDUP_STEP_UP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUILDUP_STEP_DOWN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BUILDUP_WEIGHT    = 3'd6;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RST_STRONG_FRACTION   = 16'd16384;
    localparam logic [CFG_DATA_W-1:0] RST_RISE_FRACTION     = 16'd3277;
    localparam logic [CFG_DATA_W-1:0] RST_VOLUME_RISE       = 16'd512;
    localparam logic [CFG_DATA_W-1:0] RST_COOLDOWN_MS       = 16'd3000;
    localparam logic [CFG_DATA_W-1:0] RST_BUILDUP_STEP_UP   = 16'd328;
    localparam logic [CFG_DATA_W-1:0] RST_BUILDUP_STEP_DOWN = 16'd655;
    localparam logic [CFG_DATA_W-1:0] RST_BUILDUP_WEIGHT    = 16'd13107;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] strong_fraction;
        logic [CFG_DATA_W-1:0] rise_fraction;
        logic [CFG_DATA_W-1:0] volume_rise;
        logic [CFG_DATA_W-1:0] cooldown_ms;
        logic [CFG_DATA_W-1:0] buildup_step_up;
        logic [CFG_DATA_W-1:0] buildup_step_down;
        logic [CFG_DATA_W-1:0] buildup_weight;
    } cfg_t;

    typedef struct packed {
        logic                start;
        logic [ENERGY_W-1:0] num;
        logic [ENERGY_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } div_rsp_t;

    function automatic logic [ENERGY_W-1:0] energy_of(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2
    );
        logic [ENERGY_W-1:0] sum;
        sum = ENERGY_W'(b0) * W_BIN0 + ENERGY_W'(b1) * W_BIN1 + ENERGY_W'(b2) * W_BIN2;
        return sum;
    endfunction

endpackage

// ===== hw/rtl/bdd_if.sv =====
interface bdd_in_if;
    logic        valid;
    logic        ready;
    logic        frame_valid;
    logic [7:0]  bin_lowest;
    logic [7:0]  bin_second;
    logic [7:0]  bin_third;
    logic [15:0] volume_level;
    logic [31:0] time_ms;

    modport source (
        output valid, frame_valid, bin_lowest, bin_second, bin_third, volume_level, time_ms,
        input  ready
    );
    modport sink (
        input  valid, frame_valid, bin_lowest, bin_second, bin_third, volume_level, time_ms,
        output ready
    );
endinterface

interface bdd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] intensity;
    logic        drop_fired;

    modport source (
        output valid, intensity, drop_fired,
        input  ready
    );
    modport sink (
        input  valid, intensity, drop_fired,
        output ready
    );
endinterface

// ===== hw/rtl/bdd_cfg_regs.sv =====
module bdd_cfg_regs
    import bdd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strong_fraction   <= RST_STRONG_FRACTION;
            cfg_reg.rise_fraction     <= RST_RISE_FRACTION;
            cfg_reg.volume_rise       <= RST_VOLUME_RISE;
            cfg_reg.cooldown_ms       <= RST_COOLDOWN_MS;
            cfg_reg.buildup_step_up   <= RST_BUILDUP_STEP_UP;
            cfg_reg.buildup_step_down <= RST_BUILDUP_STEP_DOWN;
            cfg_reg.buildup_weight    <= RST_BUILDUP_WEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STRONG_FRACTION:   cfg_reg.strong_fraction   <= cfg_data;
                REG_RISE_FRACTION:     cfg_reg.rise_fraction     <= cfg_data;
                REG_VOLUME_RISE:       cfg_reg.volume_rise       <= cfg_data;
                REG_COOLDOWN_MS:       cfg_reg.cooldown_ms       <= cfg_data;
                REG_BUILDUP_STEP_UP:   cfg_reg.buildup_step_up   <= cfg_data;
                REG_BUILDUP_STEP_DOWN: cfg_reg.buildup_step_down <= cfg_data;
                REG_BUILDUP_WEIGHT:    cfg_reg.buildup_weight    <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/bdd_div.sv =====
module bdd_div
    import bdd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [ENERGY_W-1:0] rem_reg;
    logic [ENERGY_W-1:0] den_reg;
    logic [FRAC_W-1:0]   quot_reg;

    logic [ENERGY_W:0]   trial;
    logic [ENERGY_W:0]   diff;
    logic                ge;
    logic [ENERGY_W-1:0] rem_next;

    // first step compares without shifting: numerator never exceeds divisor
    always_comb
    begin
        trial    = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge       = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = ge ? diff[ENERGY_W-1:0] : trial[ENERGY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num;
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[FRAC_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== hw/rtl/bass_drop_detector.sv =====
// channel  | dir | payload                                              | transaction
// in_ch    | in  | frame_valid, bin_lowest/second/third, volume, time   | valid & ready
// out_ch   | out | intensity, drop_fired                                | valid & ready
// cfg      | in  | cfg_index, cfg_data                                  | cfg_we
//
// a valid frame with rising bass spends most of its processing in two
// passes of the shared 16-step serial divider (normalized bass, then bass rise)
// a valid frame without rising bass skips the second pass
// an invalid frame leaves the state untouched
// reset restores the register defaults, a peak of 20.0 and clears the other persistent state
// a finished result sits in the output register while the next frame is taken;
// the sequencer waits only if that register is still full when its next result is ready
module bass_drop_detector
    import bdd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bdd_in_if.sink                in_ch,
    bdd_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_NORM   = 3'd2;
    localparam logic [2:0] S_RISE   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_WEIGHT = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // persistent detector state
    logic [ENERGY_W-1:0] prior_bass_reg;
    logic [15:0]         prior_volume_reg;
    logic [ENERGY_W-1:0] bass_peak_reg;
    logic [FRAC_W-1:0]   buildup_reg;
    logic [31:0]         last_drop_reg;
    logic                out_valid_reg;

    // per-frame working registers
    logic                frame_valid_reg;
    logic [ENERGY_W-1:0] energy_reg;
    logic [15:0]         volume_reg;
    logic [31:0]         time_reg;
    logic [ENERGY_W-1:0] den_reg;
    logic [FRAC_W-1:0]   norm_reg;
    logic [FRAC_W-1:0]   rise_reg;
    logic [FRAC_W-1:0]   drop_reg;
    logic [FRAC_W-1:0]   weighted_reg;
    logic                fired_reg;
    logic [FRAC_W-1:0]   intensity_reg;
    logic                drop_fired_reg;

    logic                accept_in;
    logic                out_free;
    logic                load_out;
    logic [ENERGY_W-1:0] energy_in;
    logic [34:0]         decay_prod;
    logic [ENERGY_W-1:0] decayed;
    logic [ENERGY_W-1:0] peak_new;
    logic [ENERGY_W-1:0] den_new;
    logic                bass_up;
    logic                vol_up;
    logic [ENERGY_W-1:0] bass_diff;
    logic [15:0]         vol_diff;
    logic [31:0]         elapsed;
    logic                fired;
    logic [FRAC_W:0]     up_sum;
    logic [FRAC_W-1:0]   ramp_up;
    logic [FRAC_W-1:0]   ramp_down;
    logic [FRAC_W-1:0]   buildup_new;
    logic [FRAC_W-1:0]   drop_val;
    logic [31:0]         weight_prod;
    logic [FRAC_W:0]     weight_full;
    logic [FRAC_W-1:0]   weighted_sat;
    logic [FRAC_W-1:0]   result;

    bdd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign accept_in         = in_ch.valid && in_ch.ready;
    assign out_free          = !out_valid_reg || out_ch.ready;
    assign load_out          = (state_reg == S_FINISH) && out_free;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.intensity  = intensity_reg;
    assign out_ch.drop_fired = drop_fired_reg;

    always_comb
    begin
        energy_in  = energy_of(in_ch.bin_lowest, in_ch.bin_second, in_ch.bin_third);
        decay_prod = 35'(bass_peak_reg) * 35'(PEAK_DECAY);
        decayed    = decay_prod[33:16];
        peak_new   = (energy_reg > decayed) ? energy_reg : decayed;
        den_new    = (peak_new > ONE_Q8) ? peak_new : ONE_Q8;

        bass_up   = energy_reg > prior_bass_reg;
        vol_up    = volume_reg > prior_volume_reg;
        bass_diff = energy_reg - prior_bass_reg;
        vol_diff  = volume_reg - prior_volume_reg;
        elapsed   = time_reg - last_drop_reg;

        fired = (norm_reg > cfg.strong_fraction)
             && bass_up && (rise_reg > cfg.rise_fraction)
             && vol_up && (vol_diff > cfg.volume_rise)
             && (elapsed > 32'(cfg.cooldown_ms));

        up_sum    = {1'b0, buildup_reg} + {1'b0, cfg.buildup_step_up};
        ramp_up   = (up_sum > {1'b0, ONE_Q15}) ? ONE_Q15 : up_sum[FRAC_W-1:0];
        ramp_down = (buildup_reg > cfg.buildup_step_down)
                  ? buildup_reg - cfg.buildup_step_down : '0;

        if (fired)
            buildup_new = '0;
        else if (bass_up && vol_up)
            buildup_new = ramp_up;
        else
            buildup_new = ramp_down;

        drop_val = fired ? HALF_Q15 + {1'b0, norm_reg[FRAC_W-1:1]} : '0;

        weight_prod  = 32'(buildup_reg) * 32'(cfg.buildup_weight);
        weight_full  = weight_prod[31:15];
        weighted_sat = (weight_full > {1'b0, ONE_Q15}) ? ONE_Q15 : weight_full[FRAC_W-1:0];

        result = (drop_reg > weighted_reg) ? drop_reg : weighted_reg;
    end

    // divider requests: normalized bass in prep, bass rise after it when bass is rising
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = energy_reg;
        div_req.den   = den_new;
        if (state_reg == S_PREP)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == S_NORM)
        begin
            div_req.start = div_rsp.done && bass_up;
            div_req.num   = bass_diff;
            div_req.den   = den_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                    state_next = in_ch.frame_valid ? S_PREP : S_FINISH;
            end
            S_PREP:
                state_next = S_NORM;
            S_NORM:
            begin
                if (div_rsp.done)
                    state_next = bass_up ? S_RISE : S_UPDATE;
            end
            S_RISE:
            begin
                if (div_rsp.done)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
                state_next = S_WEIGHT;
            S_WEIGHT:
                state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            prior_bass_reg   <= '0;
            prior_volume_reg <= '0;
            bass_peak_reg    <= PEAK_RESET;
            buildup_reg      <= '0;
            last_drop_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_PREP)
                bass_peak_reg <= peak_new;
            if (state_reg == S_UPDATE)
            begin
                buildup_reg      <= buildup_new;
                prior_bass_reg   <= energy_reg;
                prior_volume_reg <= volume_reg;
                if (fired)
                    last_drop_reg <= time_reg;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            frame_valid_reg <= in_ch.frame_valid;
            energy_reg      <= energy_in;
            volume_reg      <= in_ch.volume_level;
            time_reg        <= in_ch.time_ms;
            // invalid frame: zero result
            drop_reg        <= '0;
            weighted_reg    <= '0;
            fired_reg       <= 1'b0;
        end
        if (state_reg == S_PREP)
            den_reg <= den_new;
        if (state_reg == S_NORM && div_rsp.done)
        begin
            norm_reg <= div_rsp.quot;
            rise_reg <= '0;
        end
        if (state_reg == S_RISE && div_rsp.done)
            rise_reg <= div_rsp.quot;
        if (state_reg == S_UPDATE)
        begin
            drop_reg  <= drop_val;
            fired_reg <= fired;
        end
        if (state_reg == S_WEIGHT)
            weighted_reg <= frame_valid_reg ? weighted_sat : '0;
        if (load_out)
        begin
            intensity_reg  <= result;
            drop_fired_reg <= fired_reg;
        end
    end

endmodule

// ===== hw/rtl/bdd_checker.sv =====
module bdd_checker
    import bdd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [FRAC_W-1:0] intensity,
    input logic              drop_fired
);

    // busy after every input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a frame is in work");

    // a drop always reports at least half intensity
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && drop_fired) |-> (intensity >= HALF_Q15))
        else $error("drop with low intensity");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (intensity <= ONE_Q15))
        else $error("intensity above one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(intensity) && $stable(drop_fired)))
        else $error("stalled result changed");

endmodule

bind bass_drop_detector bdd_checker u_bdd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .intensity  (out_ch.intensity),
    .drop_fired (out_ch.drop_fired)
);
